FILE: src/mcfp_pkg.sv
// Shared constants, codes and types of the motor command frame parser.
package mcfp_pkg;

    localparam int unsigned MAX_DATA_WORDS_DEF = 4;
    localparam logic [15:0] DEFAULT_DEST       = 16'h0FF0;
    localparam logic [7:0]  MIN_LEN            = 8'd4;
    localparam logic [7:0]  MAX_LEN            = 8'd12;
    // Byte position that completes the first data word
    localparam logic [8:0]  FIRST_WORD_POS     = 9'd6;
    // Number of data words that the outputs show
    localparam int unsigned OUT_WORDS          = 4;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_LEN = 2'd1,
        STATUS_BAD_SUM = 2'd2
    } status_t;

    // One finished frame, as handed from decoder to output stage
    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_length;
        logic [15:0] dest_id;
        logic [15:0] op_code;
        logic [2:0]  word_count;
        logic [15:0] word_zero;
        logic [15:0] word_one;
        logic [15:0] word_two;
        logic [15:0] word_three;
        logic [7:0]  received_sum;
    } result_t;

    // Length byte is usable: even and from MIN_LEN to MAX_LEN
    function automatic logic length_ok(input logic [7:0] len);
        length_ok = (len >= MIN_LEN) && (len <= MAX_LEN) && !len[0];
    endfunction

endpackage

FILE: src/mcfp_byte_if.sv
// Request channel that carries one received frame byte.
interface mcfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/mcfp_result_if.sv
// Request channel that carries one decoded frame result.
interface mcfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  frame_length;
    logic [15:0] dest_id;
    logic [15:0] op_code;
    logic [2:0]  word_count;
    logic [15:0] word_zero;
    logic [15:0] word_one;
    logic [15:0] word_two;
    logic [15:0] word_three;
    logic [7:0]  received_sum;

    modport source (output valid, output status, output frame_length, output dest_id,
                    output op_code, output word_count, output word_zero, output word_one,
                    output word_two, output word_three, output received_sum, input ready);
    modport sink   (input valid, input status, input frame_length, input dest_id,
                    input op_code, input word_count, input word_zero, input word_one,
                    input word_two, input word_three, input received_sum, output ready);
endinterface

FILE: src/mcfp_input_stage.sv
// Input register that holds one received byte until the decoder takes it.
module mcfp_input_stage
    import mcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Accept a new request when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    a_take_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> valid_reg)
        else $error("byte taken from an empty input register");

endmodule

FILE: src/mcfp_decoder.sv
// Frame state and per-byte decode; presents the result on a frame's last byte.
module mcfp_decoder
    import mcfp_pkg::*;
#(
    parameter int unsigned MAX_DATA_WORDS = MAX_DATA_WORDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       last,
    output result_t    result
);

    logic [8:0]  pos_reg,   pos_next;
    logic [7:0]  len_reg,   len_next;
    logic [7:0]  sum_reg,   sum_next;
    logic [7:0]  hold_reg,  hold_next;
    logic [15:0] dest_reg,  dest_next;
    logic [15:0] op_reg,    op_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] word_store_reg [MAX_DATA_WORDS];

    logic        at_length;
    logic        len_ok;
    logic        byte_ok;
    logic [15:0] word;
    logic [7:0]  word_idx;
    logic        word_write;
    logic [7:0]  count_raw;
    logic [15:0] words_out [OUT_WORDS];

    assign at_length  = (pos_reg == 9'd0);
    assign last       = !at_length && (pos_reg == ({1'b0, len_reg} + 9'd1));
    assign len_ok     = length_ok(len_reg);
    assign byte_ok    = length_ok(rx_byte);
    assign word       = {hold_reg, rx_byte};
    assign word_idx   = pos_reg[8:1] - FIRST_WORD_POS[8:1];
    assign word_write = step && !at_length && !last && len_ok && !pos_reg[0]
                        && (pos_reg >= FIRST_WORD_POS);
    assign count_raw  = {1'b0, rx_byte[7:1]} - {1'b0, MIN_LEN[7:1]};

    // Advance the frame state by one byte
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        dest_next  = dest_reg;
        op_next    = op_reg;
        count_next = count_reg;
        if (step)
        begin
            priority if (at_length)
            begin
                len_next = rx_byte;
                sum_next = rx_byte;
                if (byte_ok)
                begin
                    count_next = count_raw[2:0];
                end
                pos_next = 9'd1;
            end
            else if (last)
            begin
                pos_next = 9'd0;
            end
            else
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + 9'd1;
                if (len_ok)
                begin
                    if (pos_reg[0])
                    begin
                        hold_next = rx_byte;
                    end
                    else if (pos_reg == 9'd2)
                    begin
                        dest_next = word;
                    end
                    else if (pos_reg == 9'd4)
                    begin
                        op_next = word;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            dest_reg  <= DEFAULT_DEST;
            op_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            dest_reg  <= dest_next;
            op_reg    <= op_next;
            count_reg <= count_next;
        end
    end

    // Store data words; words past the store depth are dropped
    for (genvar e = 0; e < MAX_DATA_WORDS; e++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (word_write && (word_idx == 8'(e)))
            begin
                word_store_reg[e] <= word;
            end
        end
    end

    // Show stored words; slots beyond the store depth read as zero
    for (genvar k = 0; k < OUT_WORDS; k++)
    begin : g_out
        if (k < MAX_DATA_WORDS)
        begin : g_used
            assign words_out[k] = word_store_reg[k];
        end
        else
        begin : g_absent
            assign words_out[k] = '0;
        end
    end

    // Assemble the result of the frame that ends on this byte
    always_comb
    begin
        result.frame_length = len_reg;
        result.dest_id      = dest_reg;
        result.op_code      = op_reg;
        result.word_count   = count_reg;
        result.word_zero    = words_out[0];
        result.word_one     = words_out[1];
        result.word_two     = words_out[2];
        result.word_three   = words_out[3];
        result.received_sum = rx_byte;
        priority if (!len_ok)
        begin
            result.status = STATUS_BAD_LEN;
        end
        else if (rx_byte != sum_reg)
        begin
            result.status = STATUS_BAD_SUM;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ({1'b0, len_reg} + 9'd1))
        else $error("byte position ran past the frame end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("word count out of range");

    a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step && at_length) |=> (pos_reg == 9'd1) && (len_reg == $past(rx_byte)))
        else $error("length byte not taken");

endmodule

FILE: src/mcfp_output_stage.sv
// Result register that holds a finished frame until the sink takes it.
module mcfp_output_stage
    import mcfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new result when empty or when the held one leaves now
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result overwritten before it was taken");

endmodule

FILE: src/motor_command_frame_parser.sv
// Top level of the motor command frame parser.
//
//   channel  direction  payload                                  transfer
//   rx       in         rx_byte[7:0]                             valid & ready
//   frame    out        status, frame_length, dest_id, op_code,  valid & ready
//                       word_count, word_zero..word_three,
//                       received_sum
//
// One byte a cycle while the result register has room: each byte passes the
// input register, is decoded combinationally against the frame state and, on
// a frame's last byte, has its result loaded into the result register, which
// drives the frame channel.
// Reset (rst_n low) empties both registers and returns the decoder to
// expecting a length byte with the default destination.
// A stalled result holds the decoder; one more byte waits in the input register.
module motor_command_frame_parser
    import mcfp_pkg::*;
#(
    parameter int unsigned MAX_DATA_WORDS = MAX_DATA_WORDS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    mcfp_byte_if.sink    rx,
    mcfp_result_if.source frame
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       step;
    logic       last;
    logic       free;
    result_t    dec_result;
    result_t    out_result;

    // Decode the held byte whenever the result register can take its outcome
    assign step = held_valid && free;

    mcfp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_byte    (rx.rx_byte),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    mcfp_decoder #(
        .MAX_DATA_WORDS (MAX_DATA_WORDS)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (held_byte),
        .last    (last),
        .result  (dec_result)
    );

    mcfp_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && last),
        .result     (dec_result),
        .free       (free),
        .out_valid  (frame.valid),
        .out_ready  (frame.ready),
        .out_result (out_result)
    );

    // Drive the result payload
    assign frame.status       = out_result.status;
    assign frame.frame_length = out_result.frame_length;
    assign frame.dest_id      = out_result.dest_id;
    assign frame.op_code      = out_result.op_code;
    assign frame.word_count   = out_result.word_count;
    assign frame.word_zero    = out_result.word_zero;
    assign frame.word_one     = out_result.word_one;
    assign frame.word_two     = out_result.word_two;
    assign frame.word_three   = out_result.word_three;
    assign frame.received_sum = out_result.received_sum;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the motor command frame parser.
module tb_top;
    import mcfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;

    mcfp_byte_if   rx_ch();
    mcfp_result_if frame_ch();

    motor_command_frame_parser dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    // Idle rates in percent for the byte sender and the result receiver
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned mismatches;

    // Expected frame results, oldest first
    result_t pending_frames[$];

    // Parser state as the testbench tracks it
    logic [8:0]  pos_q;
    logic [7:0]  len_q;
    logic [7:0]  sum_q;
    logic [7:0]  hi_q;
    logic [15:0] dest_q;
    logic [15:0] opcode_q;
    logic [2:0]  count_q;
    logic [15:0] words_q[OUT_WORDS];

    // Free-running clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a run that goes on past CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Randomise result back-pressure
    always @(negedge clk)
    begin
        frame_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic bit len_usable(input logic [7:0] len);
        return (len >= 8'd4) && (len <= 8'd12) && (len[0] == 1'b0);
    endfunction

    function automatic void frame_state_reset();
        pos_q    = '0;
        len_q    = '0;
        sum_q    = '0;
        hi_q     = '0;
        dest_q   = 16'h0FF0;
        opcode_q = '0;
        count_q  = '0;
        foreach (words_q[i])
            words_q[i] = '0;
    endfunction

    // Advance the tracked parser by one byte; flag and build a result on a frame's end
    function automatic bit parse_byte(input logic [7:0] b, output result_t res);
        logic [15:0] word;
        logic [8:0]  idx;
        res = '0;
        if (pos_q == 9'd0)
        begin
            len_q = b;
            sum_q = b;
            if (len_usable(b))
                count_q = 3'((b - 8'd4) >> 1);
            pos_q = 9'd1;
            return 1'b0;
        end
        if (pos_q == {1'b0, len_q} + 9'd1)
        begin
            if (!len_usable(len_q))
                res.status = STATUS_BAD_LEN;
            else if (b != sum_q)
                res.status = STATUS_BAD_SUM;
            else
                res.status = STATUS_OK;
            res.frame_length = len_q;
            res.dest_id      = dest_q;
            res.op_code      = opcode_q;
            res.word_count   = count_q;
            res.word_zero    = words_q[0];
            res.word_one     = words_q[1];
            res.word_two     = words_q[2];
            res.word_three   = words_q[3];
            res.received_sum = b;
            pos_q = 9'd0;
            return 1'b1;
        end
        sum_q = sum_q + b;
        if (len_usable(len_q))
        begin
            if (pos_q[0])
                hi_q = b;
            else
            begin
                word = {hi_q, b};
                if (pos_q == 9'd2)
                    dest_q = word;
                else if (pos_q == 9'd4)
                    opcode_q = word;
                else if (pos_q >= FIRST_WORD_POS)
                begin
                    idx = (pos_q - FIRST_WORD_POS) >> 1;
                    if (idx < OUT_WORDS)
                        words_q[idx] = word;
                end
            end
        end
        pos_q = pos_q + 9'd1;
        return 1'b0;
    endfunction

    // Offer one byte, hold it until the request is taken, then predict
    task automatic send_byte(input logic [7:0] b);
        result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
        if (parse_byte(b, res))
            pending_frames.push_back(res);
        @(negedge clk);
    endtask

    // Send length, body and checksum; spoil the checksum when asked
    task automatic send_frame(input logic [7:0] len, input byte_q_t body, input bit good_sum);
        logic [7:0] sum;
        sum = len;
        send_byte(len);
        foreach (body[i])
        begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        if (!good_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    function automatic byte_q_t random_body(input int unsigned n);
        byte_q_t body;
        repeat (n)
            body.push_back(8'($urandom));
        return body;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %h, got %h", $realtime, name, exp_val, act_val);
        end
    endfunction

    // Compare each accepted result with the oldest expected frame
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no frame outstanding", $realtime);
            end
            else
            begin
                exp_res = pending_frames.pop_front();
                check_field("status",       16'(exp_res.status),       16'(frame_ch.status));
                check_field("frame_length", 16'(exp_res.frame_length), 16'(frame_ch.frame_length));
                check_field("dest_id",      exp_res.dest_id,           frame_ch.dest_id);
                check_field("op_code",      exp_res.op_code,           frame_ch.op_code);
                check_field("word_count",   16'(exp_res.word_count),   16'(frame_ch.word_count));
                check_field("word_zero",    exp_res.word_zero,         frame_ch.word_zero);
                check_field("word_one",     exp_res.word_one,          frame_ch.word_one);
                check_field("word_two",     exp_res.word_two,          frame_ch.word_two);
                check_field("word_three",   exp_res.word_three,        frame_ch.word_three);
                check_field("received_sum", 16'(exp_res.received_sum), 16'(frame_ch.received_sum));
            end
        end
    end

    // Full-length frame first so that every data word is written before any is read
    task automatic test_directed_frames();
        byte_q_t body;
        body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
                 8'hA5, 8'h5A, 8'h5A, 8'hA5};
        send_frame(8'd12, body, 1'b1);
        // Length zero: length byte and checksum only
        body = {};
        send_frame(8'd0, body, 1'b1);
        // Shortest good length with a corrupted checksum
        body = '{8'h00, 8'h01, 8'h80, 8'hFE};
        send_frame(8'd4, body, 1'b0);
        // Odd length below the minimum
        body = '{8'h7F};
        send_frame(8'd1, body, 1'b1);
    endtask

    // Maximum length byte: 257-byte frame with a bad length
    task automatic test_longest_frame();
        // Finish any frame left open by stray bytes so the length byte lands first
        while (pos_q != 9'd0)
            send_byte(8'($urandom));
        send_frame(8'd255, random_body(255), 1'b1);
    endtask

    // Mostly well-formed frames, some bad lengths, some stray bytes
    task automatic test_random_frames(input int unsigned n_bytes);
        int unsigned start;
        int unsigned kind;
        logic [7:0]  len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                len = 8'(2 * $urandom_range(2, 6));
                send_frame(len, random_body(len), ($urandom_range(0, 99) < 85));
            end
            else if (kind < 88)
            begin
                do
                begin
                    if ($urandom_range(0, 19) == 0)
                        len = 8'($urandom_range(13, 255));
                    else
                        len = 8'($urandom_range(0, 40));
                end
                while (len_usable(len));
                send_frame(len, random_body(len), ($urandom_range(0, 1) == 1));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        frame_ch.ready = 1'b0;
        cycle_count    = 0;
        bytes_sent     = 0;
        mismatches     = 0;
        tx_idle_pct    = 11;
        rx_idle_pct    = 75;
        frame_state_reset();

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_random_frames(400);

        tx_idle_pct = 75;
        rx_idle_pct = 11;
        test_longest_frame();
        test_random_frames(350);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(400);

        rx_ch.valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_frames.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
